/* sv/scd_pkg.sv */
// shared types, constants and helper functions for the stereo chorus block
// no dependencies; front, queue, back and top refer to it by scoped names
package scd_pkg;

    // ring geometry
    localparam int RING_DEPTH = 131072;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;

    // arithmetic constants
    localparam int GAIN_ONE    = 65536;
    localparam int SMOOTH_COEF = 16777;

    // largest usable delay, (depth - 1) samples in q16
    localparam logic [RING_AW+15:0] DMAX = (RING_AW+16)'(longint'(RING_DEPTH - 1) << 16);
    // one full ring in q16, for wrapping a negative read position
    localparam logic signed [RING_AW+17:0] RING_SPAN =
        (RING_AW+18)'(longint'(RING_DEPTH) << 16);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [16:0] RST_MIX   = 17'd32768;
    localparam logic [16:0] RST_DEPTH = 17'd32768;
    localparam logic [24:0] RST_STEP  = 25'd894785;
    localparam logic [16:0] RST_FB    = 17'd32768;
    localparam logic [32:0] RST_DMIN  = 33'd15728640;
    localparam logic [32:0] RST_SPAN  = 33'd927989760;
    localparam logic [32:0] RST_START = 33'd3145728000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIX   = 3'd0,
        CFG_DEPTH = 3'd1,
        CFG_STEP  = 3'd2,
        CFG_FB    = 3'd3,
        CFG_DMIN  = 3'd4,
        CFG_SPAN  = 3'd5,
        CFG_START = 3'd6
    } t_cfg_idx;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [16:0] mix;
        logic [16:0] depth;
        logic [24:0] step;
        logic [16:0] fb_gain;
        logic [32:0] dmin;
        logic [32:0] span;
    } t_cfg;

    // one classified item handed from front to back
    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [RING_AW-1:0] wp;
        logic [RING_AW-1:0] i0;
        logic [RING_AW-1:0] i1;
        logic [15:0]        frac;
    } t_tap_req;

    // saturate to q1.23
    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // gains above unity act as unity
    function automatic logic [16:0] clamp_gain(input logic [16:0] g);
        return (g > 17'(GAIN_ONE)) ? 17'(GAIN_ONE) : g;
    endfunction

    // quarter-wave polynomial sine, q1.15
    function automatic logic signed [15:0] sine_entry(input int unsigned idx);
        int unsigned qbits;
        int unsigned qsize;
        int unsigned quad;
        int unsigned r;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        qbits = SINE_TABLE_BITS - 2;
        qsize = 1 << qbits;
        quad  = (idx >> qbits) & 3;
        r     = idx & (qsize - 1);
        if ((quad & 1) != 0) begin
            r = qsize - r;
        end
        u  = 64'(r) << (16 - qbits);
        u2 = (u * u) >> 16;
        t  = (u2 * 64'd4640) >> 16;
        t  = 64'd42048 - t;
        t  = (u2 * t) >> 16;
        t  = 64'd102944 - t;
        s  = (u * t) >> 17;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return ((quad & 2) != 0) ? -16'(s) : 16'(s);
    endfunction

endpackage

/* sv/scd_in_if.sv */
// input stream channel: valid/ready plus one stereo sample pair
// no dependencies
interface scd_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;

    modport source(output valid, output left_in, output right_in, input ready);
    modport sink(input valid, input left_in, input right_in, output ready);
endinterface

/* sv/scd_out_if.sv */
// output stream channel: valid/ready plus one mixed stereo pair
// no dependencies
interface scd_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;

    modport source(output valid, output left_out, output right_out, input ready);
    modport sink(input valid, input left_out, input right_out, output ready);
endinterface

/* sv/scd_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module scd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/scd_front.sv */
// front end: accepts sample pairs, runs lfo, smoothing and tap addressing
// depends on scd_pkg and scd_in_if
module scd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scd_pkg::t_cfg       i_cfg,
    input  logic                i_load_start,
    input  logic [32:0]         i_start_value,
    input  logic                i_hold,
    scd_in_if.sink              i_in,
    output logic                o_push,
    output scd_pkg::t_tap_req   o_req,
    input  logic                i_push_ready
);

    localparam int AW = scd_pkg::RING_AW;

    typedef enum logic [6:0] {
        F_IDLE   = 7'b0000001,
        F_LFO    = 7'b0000010,
        F_TGT    = 7'b0000100,
        F_DIFF   = 7'b0001000,
        F_SMOOTH = 7'b0010000,
        F_ADDR   = 7'b0100000,
        F_PUSH   = 7'b1000000
    } t_fstate;

    t_fstate            r_state;
    t_fstate            n_state;
    logic [31:0]        r_phase;
    logic [33:0]        r_smooth;
    logic [AW-1:0]      r_wp;
    logic signed [23:0] r_left;
    logic signed [23:0] r_right;
    logic signed [15:0] r_sine;
    logic signed [17:0] r_lfo;
    logic [33:0]        r_target;
    logic signed [50:0] r_m;
    scd_pkg::t_tap_req  r_req;

    // constant sine table
    logic signed [15:0] sine_tab [scd_pkg::SINE_N];
    for (genvar k = 0; k < scd_pkg::SINE_N; k++) begin : g_sine
        assign sine_tab[k] = scd_pkg::sine_entry(k);
    end

    // datapath terms
    logic signed [33:0]         lfo_prod;
    logic signed [17:0]         lfo_off;
    logic [48:0]                span_prod;
    logic signed [34:0]         diff;
    logic signed [50:0]         m_prod;
    logic [AW+15:0]             d_cl;
    logic signed [AW+17:0]      rp_raw;
    logic signed [AW+17:0]      rp;
    logic [AW-1:0]              i0;
    logic [AW-1:0]              i1;
    logic                       accept;

    assign lfo_prod  = r_sine * $signed({1'b0, scd_pkg::clamp_gain(i_cfg.depth)});
    assign lfo_off   = r_lfo + 18'sd32768;
    assign span_prod = i_cfg.span * lfo_off[15:0];
    assign diff      = $signed({1'b0, r_smooth}) - $signed({1'b0, r_target});
    assign m_prod    = diff * $signed({1'b0, 15'(scd_pkg::SMOOTH_COEF)});

    // clamp delay to the ring and wrap the read position
    always_comb begin
        d_cl   = (r_smooth > scd_pkg::DMAX) ? scd_pkg::DMAX : r_smooth[AW+15:0];
        rp_raw = $signed({2'b0, r_wp, 16'b0}) - $signed({2'b0, d_cl});
        rp     = (rp_raw < 0) ? rp_raw + scd_pkg::RING_SPAN : rp_raw;
        i0     = (rp[AW+15:16] >= AW'(scd_pkg::RING_DEPTH - 1)) ?
                 AW'(scd_pkg::RING_DEPTH - 1) : rp[AW+15:16];
        i1     = (i0 == AW'(scd_pkg::RING_DEPTH - 1)) ? '0 : i0 + 1'b1;
    end

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == F_IDLE) && !i_hold;
    assign o_push      = (r_state == F_PUSH);
    assign o_req       = r_req;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:   if (accept) n_state = F_LFO;
            F_LFO:    n_state = F_TGT;
            F_TGT:    n_state = F_DIFF;
            F_DIFF:   n_state = F_SMOOTH;
            F_SMOOTH: n_state = F_ADDR;
            F_ADDR:   n_state = F_PUSH;
            F_PUSH:   if (i_push_ready) n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // control and lfo/smoothing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_phase  <= '0;
            r_smooth <= {1'b0, scd_pkg::RST_START};
            r_wp     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_phase <= r_phase + {7'b0, i_cfg.step};
            end
            if (i_load_start) begin
                r_smooth <= {1'b0, i_start_value};
            end else if (r_state == F_SMOOTH) begin
                r_smooth <= r_smooth - {{7{r_m[50]}}, r_m[50:24]};
            end
            if (o_push && i_push_ready) begin
                r_wp <= (r_wp == AW'(scd_pkg::RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left  <= i_in.left_in;
            r_right <= i_in.right_in;
            r_sine  <= sine_tab[r_phase[31:32-scd_pkg::SINE_TABLE_BITS]];
        end
        if (r_state == F_LFO) begin
            r_lfo <= lfo_prod[33:16];
        end
        if (r_state == F_TGT) begin
            r_target <= {1'b0, i_cfg.dmin} + {1'b0, span_prod[48:16]};
        end
        if (r_state == F_DIFF) begin
            r_m <= m_prod;
        end
        if (r_state == F_ADDR) begin
            r_req.left  <= r_left;
            r_req.right <= r_right;
            r_req.wp    <= r_wp;
            r_req.i0    <= i0;
            r_req.i1    <= i1;
            r_req.frac  <= rp[15:0];
        end
    end

endmodule

/* sv/scd_queue.sv */
// short fifo of classified items between front and back
// depends on scd_pkg
module scd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scd_pkg::t_tap_req i_req,
    output logic              o_push_ready,
    output logic              o_valid,
    output scd_pkg::t_tap_req o_req,
    input  logic              i_pop
);

    localparam int QD = scd_pkg::QUEUE_DEPTH;
    localparam int QA = scd_pkg::QUEUE_AW;
    localparam int QC = scd_pkg::QUEUE_CW;

    scd_pkg::t_tap_req r_slot [QD];
    logic [QA-1:0]     r_wr;
    logic [QA-1:0]     r_rd;
    logic [QC-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = (r_count < QC'(QD));
    assign o_valid      = (r_count != '0);
    assign o_req        = r_slot[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QA'(QD - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QA'(QD - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_req;
        end
    end

endmodule

/* sv/scd_back.sv */
// back end: ring write, two tap reads, interpolation, feedback and mix
// depends on scd_pkg, scd_out_if and scd_ram
module scd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scd_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  scd_pkg::t_tap_req i_req,
    output logic              o_pop,
    output logic              o_busy,
    scd_out_if.source         o_out
);

    localparam int AW = scd_pkg::RING_AW;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_WR   = 8'b00000010,
        S_RD0  = 8'b00000100,
        S_RD1  = 8'b00001000,
        S_P0   = 8'b00010000,
        S_TAP  = 8'b00100000,
        S_FB   = 8'b01000000,
        S_MIX  = 8'b10000000
    } t_bstate;

    t_bstate            r_state;
    t_bstate            n_state;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic               r_out_valid;
    scd_pkg::t_tap_req  r_req;
    logic signed [23:0] r_fb    [2];
    logic signed [23:0] r_d0    [2];
    logic signed [23:0] r_d1    [2];
    logic signed [41:0] r_p0    [2];
    logic signed [23:0] r_tap   [2];
    logic signed [41:0] r_pdry  [2];
    logic signed [23:0] r_out   [2];

    logic signed [23:0] x       [2];
    logic signed [23:0] wval    [2];
    logic signed [23:0] rdata   [2];
    logic signed [40:0] c_p1    [2];
    logic signed [42:0] c_tsum  [2];
    logic signed [41:0] c_fbp   [2];
    logic signed [41:0] c_pw    [2];
    logic signed [42:0] c_msum  [2];
    logic [16:0]        inv_frac;
    logic [16:0]        wet;
    logic [16:0]        inv_wet;
    logic [16:0]        fbg;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic               load_out;

    assign x[0]     = r_req.left;
    assign x[1]     = r_req.right;
    assign inv_frac = 17'(scd_pkg::GAIN_ONE) - {1'b0, r_req.frac};
    assign wet      = scd_pkg::clamp_gain(i_cfg.mix);
    assign inv_wet  = 17'(scd_pkg::GAIN_ONE) - wet;
    assign fbg      = scd_pkg::clamp_gain(i_cfg.fb_gain);

    // ring port control, clearing pass has priority
    assign ram_we    = r_clr_busy || (r_state == S_WR);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_req.wp;
    assign ram_re    = (r_state == S_RD0) || (r_state == S_RD1);
    assign ram_raddr = (r_state == S_RD0) ? r_req.i0 : r_req.i1;

    // per-channel lanes
    for (genvar k = 0; k < 2; k++) begin : g_lane
        logic [23:0] ram_q;
        assign wval[k]   = scd_pkg::sat24(48'(x[k]) + 48'(r_fb[k]));
        assign c_p1[k]   = r_d1[k] * $signed({1'b0, r_req.frac});
        assign c_tsum[k] = 43'(r_p0[k]) + 43'(c_p1[k]);
        assign c_fbp[k]  = r_tap[k] * $signed({1'b0, fbg});
        assign c_pw[k]   = r_tap[k] * $signed({1'b0, wet});
        assign c_msum[k] = 43'(r_pdry[k]) + 43'(c_pw[k]);
        assign rdata[k]  = $signed(ram_q);

        scd_ram #(
            .WIDTH(24),
            .DEPTH(scd_pkg::RING_DEPTH)
        ) u_ring (
            .i_clk  (i_clk),
            .i_we   (ram_we),
            .i_waddr(ram_waddr),
            .i_wdata(r_clr_busy ? 24'd0 : wval[k]),
            .i_re   (ram_re),
            .i_raddr(ram_raddr),
            .o_rdata(ram_q)
        );
    end

    assign o_pop    = (r_state == S_IDLE) && !r_clr_busy && i_valid;
    assign o_busy   = r_clr_busy;
    assign load_out = (r_state == S_MIX) && (!r_out_valid || o_out.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (o_pop) n_state = S_WR;
            S_WR:    n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_P0;
            S_P0:    n_state = S_TAP;
            S_TAP:   n_state = S_FB;
            S_FB:    n_state = S_MIX;
            S_MIX:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, clearing pass and feedback state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_fb[0]     <= '0;
            r_fb[1]     <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(scd_pkg::RING_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_FB) begin
                for (int k = 0; k < 2; k++) begin
                    r_fb[k] <= scd_pkg::sat24(48'(c_fbp[k] >>> 16));
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_req;
        end
        for (int k = 0; k < 2; k++) begin
            if (r_state == S_RD1) r_d0[k] <= rdata[k];
            if (r_state == S_P0) begin
                r_d1[k] <= rdata[k];
                r_p0[k] <= r_d0[k] * $signed({1'b0, inv_frac});
            end
            if (r_state == S_TAP) r_tap[k] <= c_tsum[k][39:16];
            if (r_state == S_FB) r_pdry[k] <= x[k] * $signed({1'b0, inv_wet});
            if (load_out) r_out[k] <= scd_pkg::sat24(48'(c_msum[k] >>> 16));
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out[0];
    assign o_out.right_out = r_out[1];

    // ring write is always followed by the two tap reads
    a_wr_then_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> (r_state == S_RD0))
        else $error("ring write not followed by first tap read");

    // no item starts while the clearing pass runs
    a_no_pop_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == S_IDLE) && !o_pop)
        else $error("item started during clearing pass");

    // a new result only comes out of the mix step
    a_out_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_MIX))
        else $error("output valid rose outside mix step");

endmodule

/* sv/stereo_modulated_delay_chorus.sv */
// top level of the stereo lfo modulated delay chorus with feedback
// depends on scd_pkg, scd_in_if, scd_out_if, scd_front, scd_queue, scd_back
//
// usage:
//  - i_in carries one stereo q1.23 sample pair per beat, o_out one mixed pair
//  - config writes on i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle;
//    writing the start delay also reloads the smoothed delay at once
//  - throughput is set by the back end sequence on the ring ram (one write,
//    two tap reads, interpolation, feedback, mix); the back end starts no
//    new item until its mix step has handed on the result
//  - the front end (lfo, smoothing, tap address) overlaps the back end
//    through a two-entry queue
//  - after reset both delay rings are cleared, one entry a cycle, through all
//    131072 entries; i_in.ready stays low until the pass is done
//  - when the receiver stalls the result holds in the output register, the
//    next item still runs to the mix step, later ones wait in the queue
module stereo_modulated_delay_chorus (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [32:0] i_cfg_data,
    scd_in_if.sink      i_in,
    scd_out_if.source   o_out
);

    scd_pkg::t_cfg     r_cfg;
    scd_pkg::t_tap_req f_req;
    scd_pkg::t_tap_req q_req;
    logic              f_push;
    logic              q_push_ready;
    logic              q_valid;
    logic              b_pop;
    logic              b_busy;
    logic              load_start;

    assign load_start = i_cfg_we && (i_cfg_idx == scd_pkg::CFG_START);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mix     <= scd_pkg::RST_MIX;
            r_cfg.depth   <= scd_pkg::RST_DEPTH;
            r_cfg.step    <= scd_pkg::RST_STEP;
            r_cfg.fb_gain <= scd_pkg::RST_FB;
            r_cfg.dmin    <= scd_pkg::RST_DMIN;
            r_cfg.span    <= scd_pkg::RST_SPAN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scd_pkg::CFG_MIX:   r_cfg.mix     <= i_cfg_data[16:0];
                scd_pkg::CFG_DEPTH: r_cfg.depth   <= i_cfg_data[16:0];
                scd_pkg::CFG_STEP:  r_cfg.step    <= i_cfg_data[24:0];
                scd_pkg::CFG_FB:    r_cfg.fb_gain <= i_cfg_data[16:0];
                scd_pkg::CFG_DMIN:  r_cfg.dmin    <= i_cfg_data;
                scd_pkg::CFG_SPAN:  r_cfg.span    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_load_start (load_start),
        .i_start_value(i_cfg_data),
        .i_hold       (b_busy),
        .i_in         (i_in),
        .o_push       (f_push),
        .o_req        (f_req),
        .i_push_ready (q_push_ready)
    );

    scd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_req       (f_req),
        .o_push_ready(q_push_ready),
        .o_valid     (q_valid),
        .o_req       (q_req),
        .i_pop       (b_pop)
    );

    scd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_valid(q_valid),
        .i_req  (q_req),
        .o_pop  (b_pop),
        .o_busy (b_busy),
        .o_out  (o_out)
    );

endmodule
